// ----- rtl/qmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared types, constants and codes of the quad motor mixer and pulse unit.
// ----------------------------------------------------------------------------
package qmm_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int MOTOR_COUNT = 4;
    localparam int MIDX_W      = $clog2(MOTOR_COUNT);

    localparam int AXIS_W = 14;
    localparam int THR_W  = 13;
    localparam int WID_W  = 12;
    localparam int TICK_W = 16;
    localparam int MIX_W  = 16;

    localparam logic [THR_W-1:0]  ONE_THR    = THR_W'(1 << FRAC_BITS);
    localparam logic [MIX_W-1:0]  NINETENTHS = MIX_W'((9 * (1 << FRAC_BITS) + 5) / 10);

    localparam logic [TICK_W-1:0] RST_CYCLE_LEN = 16'd4000;
    localparam logic [WID_W-1:0]  RST_MIN_PULSE = 12'd1000;
    localparam logic [WID_W-1:0]  RST_MAX_PULSE = 12'd2000;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_CYCLE_LEN = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [1:0] REG_MAX_PULSE = 2'd2;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_DEMAND = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_R,
        S_MUL_Y,
        S_MIX,
        S_WID
    } t_seq_state;

    // pending width write from the mixer sequencer
    typedef struct packed {
        logic              we;
        logic [MIDX_W-1:0] idx;
        logic [WID_W-1:0]  width;
        logic              last;
    } t_pend_wr;

    // line state and start flag, as presented on the result word
    typedef struct packed {
        logic [MOTOR_COUNT-1:0] lines;
        logic                   started;
    } t_pulse_stat;

    // negate mask {pitch, roll, yaw} for each motor of the X frame
    function automatic logic [2:0] mix_neg(input logic [MIDX_W-1:0] k);
        logic [2:0] m;
        case (k)
            2'd0:    m = 3'b010;
            2'd1:    m = 3'b001;
            2'd2:    m = 3'b100;
            2'd3:    m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/qmm_mix_seq.sv -----
// ----------------------------------------------------------------------------
// qmm_mix_seq
// Mixer sequencer: one shared multiplier computes the axis products, then
// the four motor levels and their pulse widths, one motor per cycle.
// ----------------------------------------------------------------------------
module qmm_mix_seq
    import qmm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [AXIS_W-1:0] i_pitch,
    input  logic signed [AXIS_W-1:0] i_roll,
    input  logic signed [AXIS_W-1:0] i_yaw,
    input  logic [THR_W-1:0]         i_throttle,
    input  logic [WID_W-1:0]         i_min_pulse,
    input  logic [WID_W-1:0]         i_max_pulse,
    output logic                     o_busy,
    output t_pend_wr                 o_pend
);

    localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1 << FRAC_BITS);

    function automatic logic signed [AXIS_W-1:0] clamp_axis(
        input logic signed [AXIS_W-1:0] a
    );
        logic signed [AXIS_W-1:0] c;
        if (a > AXIS_ONE) begin
            c = AXIS_ONE;
        end else if (a < -AXIS_ONE) begin
            c = -AXIS_ONE;
        end else begin
            c = a;
        end
        return c;
    endfunction

    function automatic logic signed [MIX_W-1:0] term(
        input logic signed [AXIS_W-1:0] v,
        input logic                     neg
    );
        logic signed [MIX_W-1:0] x;
        x = $signed({{(MIX_W-AXIS_W){v[AXIS_W-1]}}, v});
        return neg ? -x : x;
    endfunction

    t_seq_state r_state, n_state;

    logic [MIDX_W-1:0]        r_k;
    logic [THR_W-1:0]         r_scaled;
    logic [THR_W-1:0]         r_thr;
    logic signed [AXIS_W-1:0] r_ap, r_ar, r_ay;
    logic signed [AXIS_W-1:0] r_p, r_r, r_y;
    logic [WID_W-1:0]         r_level;

    logic [THR_W+1:0]         w_thr3;
    logic [THR_W-1:0]         w_scaled;
    logic [WID_W-1:0]         w_span;
    logic signed [AXIS_W:0]   w_mul_a;
    logic signed [THR_W:0]    w_mul_b;
    logic signed [AXIS_W+THR_W+1:0] w_prod;
    logic signed [AXIS_W-1:0] w_axis_prod;
    logic [WID_W-1:0]         w_wid_frac;
    logic [MIDX_W-1:0]        w_lvl_idx;
    logic [2:0]               w_neg;
    logic signed [MIX_W-1:0]  w_mix;
    logic signed [MIX_W-1:0]  w_low;
    logic signed [MIX_W-1:0]  w_lv1;
    logic signed [MIX_W-1:0]  w_lv2;

    // 3/4 throttle
    assign w_thr3   = {2'b00, i_throttle} + {1'b0, i_throttle, 1'b0};
    assign w_scaled = w_thr3[THR_W+1:2];
    assign w_span   = (i_max_pulse >= i_min_pulse) ? (i_max_pulse - i_min_pulse) : '0;

    always_comb begin
        case (r_state)
            S_MUL_P: begin
                w_mul_a = {r_ap[AXIS_W-1], r_ap};
                w_mul_b = {1'b0, r_thr};
            end
            S_MUL_R: begin
                w_mul_a = {r_ar[AXIS_W-1], r_ar};
                w_mul_b = {1'b0, r_thr};
            end
            S_MUL_Y: begin
                w_mul_a = {r_ay[AXIS_W-1], r_ay};
                w_mul_b = {1'b0, r_thr};
            end
            S_WID: begin
                w_mul_a = {{(AXIS_W+1-WID_W){1'b0}}, r_level};
                w_mul_b = {{(THR_W+1-WID_W){1'b0}}, w_span};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod      = w_mul_a * w_mul_b;
    assign w_axis_prod = w_prod[FRAC_BITS+AXIS_W-1:FRAC_BITS];
    assign w_wid_frac  = w_prod[FRAC_BITS+WID_W-1:FRAC_BITS];

    // level of motor w_lvl_idx, clamped to [thr/2, 0.9]
    assign w_lvl_idx = (r_state == S_MIX) ? '0 : r_k + 1'b1;
    assign w_neg     = mix_neg(w_lvl_idx);
    assign w_mix     = $signed({{(MIX_W-THR_W){1'b0}}, r_scaled})
                     + term(r_p, w_neg[2]) + term(r_r, w_neg[1]) + term(r_y, w_neg[0]);
    assign w_low     = $signed({{(MIX_W-THR_W+1){1'b0}}, r_thr[THR_W-1:1]});
    assign w_lv1     = (w_mix < w_low) ? w_low : w_mix;
    assign w_lv2     = (w_lv1 > $signed(NINETENTHS)) ? $signed(NINETENTHS) : w_lv1;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_start ? S_MUL_P : S_IDLE;
            S_MUL_P: n_state = S_MUL_R;
            S_MUL_R: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_MIX;
            S_MIX:   n_state = S_WID;
            S_WID:   n_state = (r_k == MIDX_W'(MOTOR_COUNT - 1)) ? S_IDLE : S_WID;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_pend.we    = (r_state == S_WID);
        o_pend.idx   = r_k;
        o_pend.width = i_min_pulse + w_wid_frac;
        o_pend.last  = (r_k == MIDX_W'(MOTOR_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MIX) begin
                r_k <= '0;
            end else if (r_state == S_WID) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_scaled <= w_scaled;
            r_thr    <= (w_scaled > ONE_THR) ? ONE_THR : w_scaled;
            r_ap     <= clamp_axis(i_pitch);
            r_ar     <= clamp_axis(i_roll);
            r_ay     <= clamp_axis(i_yaw);
        end
        if (r_state == S_MUL_P) begin
            r_p <= w_axis_prod;
        end
        if (r_state == S_MUL_R) begin
            r_r <= w_axis_prod;
        end
        if (r_state == S_MUL_Y) begin
            r_y <= w_axis_prod;
        end
        if (r_state == S_MIX || r_state == S_WID) begin
            r_level <= w_lv2[WID_W-1:0];
        end
    end

endmodule

// ----- rtl/qmm_pulse_gen.sv -----
// ----------------------------------------------------------------------------
// qmm_pulse_gen
// Microsecond timer, pending and active pulse widths, and the four lines.
// ----------------------------------------------------------------------------
module qmm_pulse_gen
    import qmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_demand,
    input  logic [TICK_W-1:0] i_cycle_len,
    input  t_pend_wr          i_pend,
    output t_pulse_stat       o_stat
);

    logic [TICK_W-1:0]      r_ticks;
    logic [WID_W-1:0]       r_pend [MOTOR_COUNT];
    logic                   r_pend_valid;
    logic [WID_W-1:0]       r_active [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_lines;
    logic                   r_started;

    logic                   w_start;
    logic [TICK_W-1:0]      n_ticks;
    logic [WID_W-1:0]       n_active [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] n_lines;

    assign w_start = r_pend_valid && (r_ticks >= i_cycle_len);

    always_comb begin
        if (w_start) begin
            n_ticks = '0;
        end else if (r_ticks != '1) begin
            n_ticks = r_ticks + 1'b1;
        end else begin
            n_ticks = r_ticks;
        end
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            n_active[k] = w_start ? r_pend[k] : r_active[k];
            n_lines[k]  = (w_start | r_lines[k])
                        & (n_ticks < {{(TICK_W-WID_W){1'b0}}, n_active[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= RST_CYCLE_LEN;
            r_pend_valid <= 1'b0;
            r_lines      <= '0;
            r_started    <= 1'b0;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_pend[k]   <= '0;
                r_active[k] <= '0;
            end
        end else begin
            if (i_tick) begin
                r_ticks   <= n_ticks;
                r_lines   <= n_lines;
                r_started <= w_start;
                for (int k = 0; k < MOTOR_COUNT; k++) begin
                    r_active[k] <= n_active[k];
                end
                if (w_start) begin
                    r_pend_valid <= 1'b0;
                end
            end
            if (i_demand) begin
                r_started <= 1'b0;
            end
            if (i_pend.we) begin
                r_pend[i_pend.idx] <= i_pend.width;
                if (i_pend.last) begin
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

    assign o_stat.lines   = r_lines;
    assign o_stat.started = r_started;

endmodule

// ----- rtl/quad_motor_mixer_pwm_unit.sv -----
// ----------------------------------------------------------------------------
// quad_motor_mixer_pwm_unit
// X-frame quadcopter motor mixer with servo-style pulse outputs.
//
//   channel  direction  handshake                   word
//   input    in         i_in_valid / o_in_stall     command, demands
//   output   out        o_out_valid / i_out_stall   motor lines, cycle_started
//   config   in         APB psel/penable/pwrite     3 registers at 0, 4, 8
//
// A tick word's result is registered the next cycle.
// A demand word stalls the input while the mixer sequencer is busy: three axis
// products and four width products go through its one shared multiplier.
// Reset (synchronous, active low) restores register defaults and idle lines.
// A stalled result holds the input channel stalled until it is taken.
// ----------------------------------------------------------------------------
module quad_motor_mixer_pwm_unit
    import qmm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_command,
    input  logic signed [AXIS_W-1:0] i_pitch_demand,
    input  logic signed [AXIS_W-1:0] i_roll_demand,
    input  logic signed [AXIS_W-1:0] i_yaw_demand,
    input  logic [THR_W-1:0]         i_throttle_demand,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_motor1_out,
    output logic                     o_motor2_out,
    output logic                     o_motor3_out,
    output logic                     o_motor4_out,
    output logic                     o_cycle_started,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [TICK_W-1:0] r_cycle_len;
    logic [WID_W-1:0]  r_min_pulse;
    logic [WID_W-1:0]  r_max_pulse;
    logic              r_out_valid;

    logic              w_busy;
    logic              w_in_acc;
    logic              w_cfg_wr;
    t_pend_wr          w_pend;
    t_pulse_stat       w_stat;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite;
    assign o_in_stall = w_busy | (r_out_valid & i_out_stall);
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_len <= RST_CYCLE_LEN;
            r_min_pulse <= RST_MIN_PULSE;
            r_max_pulse <= RST_MAX_PULSE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_CYCLE_LEN: r_cycle_len <= pwdata[TICK_W-1:0];
                REG_MIN_PULSE: r_min_pulse <= pwdata[WID_W-1:0];
                REG_MAX_PULSE: r_max_pulse <= pwdata[WID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CYCLE_LEN: prdata = {{(PDATA_W-TICK_W){1'b0}}, r_cycle_len};
            REG_MIN_PULSE: prdata = {{(PDATA_W-WID_W){1'b0}}, r_min_pulse};
            REG_MAX_PULSE: prdata = {{(PDATA_W-WID_W){1'b0}}, r_max_pulse};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    qmm_mix_seq u_mix_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc & (i_command == CMD_DEMAND)),
        .i_pitch     (i_pitch_demand),
        .i_roll      (i_roll_demand),
        .i_yaw       (i_yaw_demand),
        .i_throttle  (i_throttle_demand),
        .i_min_pulse (r_min_pulse),
        .i_max_pulse (r_max_pulse),
        .o_busy      (w_busy),
        .o_pend      (w_pend)
    );

    qmm_pulse_gen u_pulse_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_in_acc & (i_command == CMD_TICK)),
        .i_demand    (w_in_acc & (i_command == CMD_DEMAND)),
        .i_cycle_len (r_cycle_len),
        .i_pend      (w_pend),
        .o_stat      (w_stat)
    );

    assign o_out_valid     = r_out_valid;
    assign o_motor1_out    = w_stat.lines[0];
    assign o_motor2_out    = w_stat.lines[1];
    assign o_motor3_out    = w_stat.lines[2];
    assign o_motor4_out    = w_stat.lines[3];
    assign o_cycle_started = w_stat.started;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_in_acc)
        else $error("word accepted while mixer busy");

    a_demand_starts_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == CMD_DEMAND) |=> w_busy)
        else $error("demand did not start the mixer");

    a_rise_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_motor1_out) |-> o_cycle_started)
        else $error("pulse line rose outside a group start");

endmodule

// ----- tb/quad_motor_mixer_pwm_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quad_motor_mixer_pwm_unit_tb
// Self-checking bench for the X-frame motor mixer and its pulse outputs.
// Tick and demand words are sent with random gaps and output stalls. A
// behavioral mixer and pulse timer in the bench predicts the line levels and
// the start flag of every word. Registers are written and read back over APB
// between phases: zero and maximal cycle length, full and inverted pulse spans,
// and a write to an unused address. The first phase runs on the reset values.
// ----------------------------------------------------------------------------
module quad_motor_mixer_pwm_unit_tb;
    import qmm_pkg::*;

    localparam int         WATCHDOG_CYCLES  = 5000;
    localparam int         SHOWN_MISMATCHES = 10;
    localparam int         UNITY            = 1 << FRAC_BITS;
    localparam int         MIX_BUSY_CYCLES  = 8;
    localparam logic [1:0] REG_SPARE        = 2'd3;

    typedef struct packed {
        logic [MOTOR_COUNT-1:0] lines;
        logic                   started;
    } t_line_word;

    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_in_valid        = 1'b0;
    logic                     o_in_stall;
    logic                     i_command         = CMD_TICK;
    logic signed [AXIS_W-1:0] i_pitch_demand    = '0;
    logic signed [AXIS_W-1:0] i_roll_demand     = '0;
    logic signed [AXIS_W-1:0] i_yaw_demand      = '0;
    logic [THR_W-1:0]         i_throttle_demand = '0;
    logic                     o_out_valid;
    logic                     i_out_stall       = 1'b0;
    logic                     o_motor1_out;
    logic                     o_motor2_out;
    logic                     o_motor3_out;
    logic                     o_motor4_out;
    logic                     o_cycle_started;
    logic                     psel              = 1'b0;
    logic                     penable           = 1'b0;
    logic                     pwrite            = 1'b0;
    logic [PADDR_W-1:0]       paddr             = '0;
    logic [PDATA_W-1:0]       pwdata            = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // bench copy of the registers and the pulse timer
    logic [TICK_W-1:0]  cycle_len_reg;
    logic [WID_W-1:0]   min_pulse_reg;
    logic [WID_W-1:0]   max_pulse_reg;
    logic [TICK_W-1:0]  ticks_since;
    logic [WID_W-1:0]   queued_width [MOTOR_COUNT];
    logic               queued_ok;
    logic [WID_W-1:0]   live_width [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] line_state;

    t_line_word line_words_due [$];
    int         mismatches  = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;

    quad_motor_mixer_pwm_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_pitch_demand    (i_pitch_demand),
        .i_roll_demand     (i_roll_demand),
        .i_yaw_demand      (i_yaw_demand),
        .i_throttle_demand (i_throttle_demand),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_motor1_out      (o_motor1_out),
        .o_motor2_out      (o_motor2_out),
        .o_motor3_out      (o_motor3_out),
        .o_motor4_out      (o_motor4_out),
        .o_cycle_started   (o_cycle_started),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // advance the mixer and pulse timer by one accepted word
    task automatic predict_word(
        input  logic                     cmd,
        input  logic signed [AXIS_W-1:0] pitch,
        input  logic signed [AXIS_W-1:0] roll,
        input  logic signed [AXIS_W-1:0] yaw,
        input  logic [THR_W-1:0]         thr,
        output t_line_word               word
    );
        int scaled;
        int thr_m;
        int low;
        int lvl;
        int span;
        int src [3];
        int prod [3];
        int mix [MOTOR_COUNT];
        word.started = 1'b0;
        if (cmd == CMD_DEMAND) begin
            scaled = (int'(thr) * 3) >>> 2;
            thr_m  = (scaled > UNITY) ? UNITY : scaled;
            src    = '{int'(pitch), int'(roll), int'(yaw)};
            for (int j = 0; j < 3; j++) begin
                if (src[j] < -UNITY) src[j] = -UNITY;
                if (src[j] > UNITY)  src[j] = UNITY;
                prod[j] = (src[j] * thr_m) >>> FRAC_BITS;
            end
            mix[0] = scaled + prod[0] - prod[1] + prod[2];
            mix[1] = scaled + prod[0] + prod[1] - prod[2];
            mix[2] = scaled - prod[0] + prod[1] + prod[2];
            mix[3] = scaled - prod[0] - prod[1] - prod[2];
            low  = thr_m / 2;
            span = int'(max_pulse_reg) - int'(min_pulse_reg);
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                lvl = (mix[k] < low) ? low : mix[k];
                if (lvl > int'(NINETENTHS)) lvl = int'(NINETENTHS);
                if (max_pulse_reg >= min_pulse_reg) begin
                    queued_width[k] = WID_W'(int'(min_pulse_reg) + ((lvl * span) >>> FRAC_BITS));
                end else begin
                    queued_width[k] = min_pulse_reg;
                end
            end
            queued_ok = 1'b1;
        end else begin
            if (queued_ok && ticks_since >= cycle_len_reg) begin
                live_width    = queued_width;
                queued_ok     = 1'b0;
                ticks_since   = '0;
                line_state    = '1;
                word.started  = 1'b1;
            end else if (ticks_since != '1) begin
                ticks_since++;
            end
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                if (ticks_since >= TICK_W'(live_width[k])) line_state[k] = 1'b0;
            end
        end
        word.lines = line_state;
    endtask

    task automatic send_word(
        input logic                     cmd,
        input logic signed [AXIS_W-1:0] pitch,
        input logic signed [AXIS_W-1:0] roll,
        input logic signed [AXIS_W-1:0] yaw,
        input logic [THR_W-1:0]         thr
    );
        t_line_word word;
        while (!quiet && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_command         <= cmd;
        i_pitch_demand    <= pitch;
        i_roll_demand     <= roll;
        i_yaw_demand      <= yaw;
        i_throttle_demand <= thr;
        i_in_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(cmd, pitch, roll, yaw, thr, word);
        line_words_due.push_back(word);
        @(negedge i_clk);
    endtask

    task automatic send_random_item(input int thr_cap);
        logic signed [AXIS_W-1:0] ax [3];
        logic [THR_W-1:0]         thr;
        int                       shape;
        if ($urandom_range(99) < 12) begin
            shape = $urandom_range(9);
            for (int j = 0; j < 3; j++) begin
                ax[j] = (shape < 7) ? AXIS_W'(int'($urandom_range(8192)) - 4096)
                                    : AXIS_W'($urandom);
            end
            thr = (shape < 7) ? THR_W'($urandom_range(thr_cap)) : THR_W'($urandom);
            send_word(CMD_DEMAND, ax[0], ax[1], ax[2], thr);
        end else begin
            send_word(CMD_TICK, AXIS_W'($urandom), AXIS_W'($urandom),
                      AXIS_W'($urandom), THR_W'($urandom));
        end
    endtask

    // all results taken and the mixer done with the last demand
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (line_words_due.size() != 0) @(negedge i_clk);
        repeat (MIX_BUSY_CYCLES + 2) @(negedge i_clk);
    endtask

    // APB write, then read back except at the spare address; upper data bits carry noise
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] data;
        mask = (idx == REG_CYCLE_LEN) ? 32'h0000_FFFF : 32'h0000_0FFF;
        data = ($urandom & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_CYCLE_LEN: cycle_len_reg = data[TICK_W-1:0];
            REG_MIN_PULSE: min_pulse_reg = data[WID_W-1:0];
            REG_MAX_PULSE: max_pulse_reg = data[WID_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        if (idx != REG_SPARE) begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== (data & mask)) begin
                note_mismatch($sformatf("register %0d read %h, expected %h",
                                        idx, prdata, data & mask));
            end
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_regs(input int cyc, input int lo, input int hi);
        write_reg(REG_CYCLE_LEN, cyc);
        write_reg(REG_MIN_PULSE, lo);
        write_reg(REG_MAX_PULSE, hi);
    endtask

    task automatic test_reset_state();
        send_word(CMD_TICK, '0, '0, '0, '0);
        send_word(CMD_DEMAND, '0, '0, '0, THR_W'(4096));
        send_word(CMD_TICK, '0, '0, '0, '0);
        send_word(CMD_TICK, '0, '0, '0, '0);
    endtask

    // zero cycle length: every demand restarts the group on the next tick
    task automatic test_axis_extremes();
        int axis_sets [5][3] = '{'{8191, -8192, 4097}, '{-4097, 4096, -4096},
                                 '{0, 0, 0}, '{-8192, 8191, 2048},
                                 '{4096, 4096, 4096}};
        int thr_set [5] = '{8191, 4096, 0, 5462, 4095};
        wait_idle();
        set_regs(0, 2, 40);
        for (int i = 0; i < 5; i++) begin
            send_word(CMD_DEMAND, AXIS_W'(axis_sets[i][0]), AXIS_W'(axis_sets[i][1]),
                      AXIS_W'(axis_sets[i][2]), THR_W'(thr_set[i]));
            send_word(CMD_TICK, '0, '0, '0, '0);
        end
        send_word(CMD_DEMAND, AXIS_W'(1000), AXIS_W'(-1000), AXIS_W'(500), THR_W'(2000));
        send_word(CMD_DEMAND, AXIS_W'(-300), AXIS_W'(200), AXIS_W'(100), THR_W'(3000));
        send_word(CMD_TICK, '0, '0, '0, '0);
    endtask

    task automatic test_inverted_span();
        wait_idle();
        write_reg(REG_MIN_PULSE, 30);
        write_reg(REG_MAX_PULSE, 5);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_word(CMD_DEMAND, AXIS_W'(2000), AXIS_W'(-2000), '0, THR_W'(4096));
        send_word(CMD_TICK, '0, '0, '0, '0);
        send_word(CMD_TICK, '0, '0, '0, '0);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_regs(65535, 4095, 4095);
        send_word(CMD_DEMAND, AXIS_W'(1234), AXIS_W'(-77), AXIS_W'(-4000), THR_W'(3500));
        repeat (30) send_random_item(4096);
        wait_idle();
        write_reg(REG_MIN_PULSE, 0);
        write_reg(REG_MAX_PULSE, 4095);
        write_reg(REG_CYCLE_LEN, 1);
        repeat (20) send_word(CMD_TICK, '0, '0, '0, '0);
        send_word(CMD_DEMAND, AXIS_W'(-4096), AXIS_W'(4096), AXIS_W'(3000), THR_W'(40));
        repeat (40) send_word(CMD_TICK, AXIS_W'($urandom), AXIS_W'($urandom),
                              AXIS_W'($urandom), THR_W'($urandom));
    endtask

    task automatic test_random_mix(input int cyc, input int lo, input int hi,
                                   input int count, input int thr_cap,
                                   input bit no_gaps, input bit mid_pause);
        wait_idle();
        set_regs(cyc, lo, hi);
        quiet = no_gaps;
        for (int i = 0; i < count; i++) begin
            if (mid_pause && i == count / 2) wait_idle();
            send_random_item(thr_cap);
        end
        quiet = 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        t_line_word want;
        t_line_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.lines   = {o_motor4_out, o_motor3_out, o_motor2_out, o_motor1_out};
            got.started = o_cycle_started;
            if (line_words_due.size() == 0) begin
                note_mismatch($sformatf("unexpected word: lines %b started %b",
                                        got.lines, got.started));
            end else begin
                want = line_words_due.pop_front();
                if (got.lines !== want.lines || got.started !== want.started) begin
                    note_mismatch($sformatf("lines(m4..m1) %b started %b, expected %b %b",
                                            got.lines, got.started,
                                            want.lines, want.started));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("quad_motor_mixer_pwm_unit regression: fail");
            $finish;
        end
    end

    initial begin
        cycle_len_reg = RST_CYCLE_LEN;
        min_pulse_reg = RST_MIN_PULSE;
        max_pulse_reg = RST_MAX_PULSE;
        ticks_since   = RST_CYCLE_LEN;
        queued_ok     = 1'b0;
        line_state    = '0;
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            queued_width[k] = '0;
            live_width[k]   = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_axis_extremes();
        test_inverted_span();
        test_register_extremes();
        test_random_mix(16, 0, 24, 260, 4096, 1'b0, 1'b1);
        test_random_mix(1, 5, 9, 230, 4096, 1'b0, 1'b0);
        test_random_mix(40, 0, 60, 230, 4096, 1'b1, 1'b0);
        test_random_mix(20, 0, 4095, 230, 60, 1'b0, 1'b0);
        test_random_mix(3, 50, 10, 200, 4096, 1'b0, 1'b0);
        test_random_mix(5, 0, 0, 100, 4096, 1'b0, 1'b0);
        repeat (3) begin
            test_random_mix($urandom_range(30), $urandom_range(30), $urandom_range(40),
                            200, 4096, 1'b0, 1'b0);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && line_words_due.size() == 0) begin
            $display("quad_motor_mixer_pwm_unit regression: pass");
        end else begin
            $display("quad_motor_mixer_pwm_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/qmm_pkg.sv
rtl/qmm_mix_seq.sv
rtl/qmm_pulse_gen.sv
rtl/quad_motor_mixer_pwm_unit.sv
tb/quad_motor_mixer_pwm_unit_tb.sv
